>>> hdl/assert_macros.svh
// assertion macros of the binarizer rtl
// no dependencies; pulled in by error_diffusion_binarizer, which carries the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define EDB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define EDB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/edb_pkg.sv
// shared types and constants of the error diffusion binarizer
// no dependencies; compiled first
`timescale 1ns / 1ps

package edb_pkg;

  localparam int PIXEL_BITS      = 8;
  localparam int LINE_WIDTH_BITS = 12;
  localparam int COL_BITS        = 11;
  localparam int ROW_BITS        = 16;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 16;

  // error weights in sixteenths
  localparam int ERR_FRAC_BITS   = 4;
  localparam int W_RIGHT         = 5;
  localparam int W_BELOW_LEFT    = 3;
  localparam int W_BELOW         = 5;
  localparam int W_BELOW_RIGHT   = 3;

  // register reset values
  localparam logic [PIXEL_BITS-1:0]      THRESHOLD_RST    = 8'd128;
  localparam logic [PIXEL_BITS-1:0]      LEVEL_LOW_RST    = 8'd0;
  localparam logic [PIXEL_BITS-1:0]      LEVEL_HIGH_RST   = 8'd255;
  localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RST   = 12'd1024;
  localparam logic [ROW_BITS-1:0]        FRAME_HEIGHT_RST = 16'd1024;

  // register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_LEVEL_LOW    = 3'd1,
    REG_LEVEL_HIGH   = 3'd2,
    REG_LINE_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]      threshold;
    logic [PIXEL_BITS-1:0]      level_low;
    logic [PIXEL_BITS-1:0]      level_high;
    logic [LINE_WIDTH_BITS-1:0] line_width;
    logic [ROW_BITS-1:0]        frame_height;
  } cfg_t;

endpackage

>>> hdl/edb_if.sv
// stream and register write interfaces of the binarizer
// depends on edb_pkg for field widths
`timescale 1ns / 1ps

// grey pixel input channel
interface edb_pix_if;
  import edb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] grey_pixel;
  modport source (output valid, output grey_pixel, input ready);
  modport sink   (input valid, input grey_pixel, output ready);
endinterface

// binary pixel result channel
interface edb_res_if;
  import edb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] bin_pixel;
  logic                  end_of_line;
  logic                  end_of_frame;
  modport source (output valid, output bin_pixel, output end_of_line,
                  output end_of_frame, input ready);
  modport sink   (input valid, input bin_pixel, input end_of_line,
                  input end_of_frame, output ready);
endinterface

// register write channel
interface edb_cfg_if;
  import edb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/edb_cfg_regs.sv
// configuration register file of the binarizer
// depends on edb_pkg and edb_cfg_if
`timescale 1ns / 1ps

module edb_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  edb_cfg_if.sink       cfg,
  output edb_pkg::cfg_t regs
);
  import edb_pkg::*;

  // always able to take a write word
  assign cfg.ready = 1'b1;

  // register write decode, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold    <= THRESHOLD_RST;
      regs.level_low    <= LEVEL_LOW_RST;
      regs.level_high   <= LEVEL_HIGH_RST;
      regs.line_width   <= LINE_WIDTH_RST;
      regs.frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_THRESHOLD:    regs.threshold    <= cfg.data[PIXEL_BITS-1:0];
        REG_LEVEL_LOW:    regs.level_low    <= cfg.data[PIXEL_BITS-1:0];
        REG_LEVEL_HIGH:   regs.level_high   <= cfg.data[PIXEL_BITS-1:0];
        REG_LINE_WIDTH:   regs.line_width   <= cfg.data[LINE_WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: regs.frame_height <= cfg.data[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/edb_line_store.sv
// one error line store: single write port, registered read port
// no dependencies; write-first on a same-address collision
`timescale 1ns / 1ps

module edb_line_store #(
  parameter int AW = 11,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1 << AW) - 1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, new data passed through on collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

>>> hdl/edb_error_path.sv
// per-pixel decision and error spreading datapath (combinational)
// depends on edb_pkg for weights and pixel width
`timescale 1ns / 1ps

module edb_error_path #(
  parameter int EB = 16
) (
  input  logic        [edb_pkg::PIXEL_BITS-1:0] grey,
  input  logic signed [EB-1:0]                  stored,
  input  logic signed [EB:0]                    carry,
  input  logic signed [EB-1:0]                  part_a,
  input  logic signed [EB-1:0]                  part_b,
  input  logic        [edb_pkg::PIXEL_BITS-1:0] threshold,
  input  logic        [edb_pkg::PIXEL_BITS-1:0] level_low,
  input  logic        [edb_pkg::PIXEL_BITS-1:0] level_high,
  output logic        [edb_pkg::PIXEL_BITS-1:0] level,
  output logic signed [EB-1:0]                  wr_value,
  output logic signed [EB-1:0]                  part_a_next,
  output logic signed [EB-1:0]                  part_b_next,
  output logic signed [EB:0]                    carry_next
);
  import edb_pkg::*;

  localparam int TW = EB + 1;   // sum, error and spread terms
  localparam int SW = EB + 2;   // saturating adder
  localparam int PW = EB + 4;   // weighted error before the shift
  localparam logic signed [SW-1:0] ERR_MAX = SW'((1 << (EB - 1)) - 1);
  localparam logic signed [SW-1:0] ERR_MIN = ~ERR_MAX;

  // add a term to a stored error and clip to the store range
  function automatic logic signed [EB-1:0] sat_add(
    input logic signed [EB-1:0] a,
    input logic signed [TW-1:0] b
  );
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > ERR_MAX) begin
      return EB'(ERR_MAX);
    end else if (s < ERR_MIN) begin
      return EB'(ERR_MIN);
    end else begin
      return EB'(s);
    end
  endfunction

  logic signed [EB-1:0] cur;
  logic signed [TW-1:0] grey16, thr16, lvl16, sum, err;
  logic signed [PW-1:0] err_w, prod_r, prod_b3, prod_b5, prod_br;
  logic signed [TW-1:0] t_r, t_bl, t_b, t_br;

  // pixel plus diffused error, then threshold
  always_comb begin
    cur    = sat_add(stored, carry);
    grey16 = $signed(TW'({grey, {ERR_FRAC_BITS{1'b0}}}));
    thr16  = $signed(TW'({threshold, {ERR_FRAC_BITS{1'b0}}}));
    sum    = grey16 + TW'(cur);
    level  = (sum > thr16) ? level_high : level_low;
    lvl16  = $signed(TW'({level, {ERR_FRAC_BITS{1'b0}}}));
    err    = sum - lvl16;
  end

  // weighted terms, floored by arithmetic shift
  always_comb begin
    err_w   = PW'(err);
    prod_r  = err_w * PW'(W_RIGHT);
    prod_b3 = err_w * PW'(W_BELOW_LEFT);
    prod_b5 = err_w * PW'(W_BELOW);
    prod_br = err_w * PW'(W_BELOW_RIGHT);
    t_r     = TW'(prod_r  >>> ERR_FRAC_BITS);
    t_bl    = TW'(prod_b3 >>> ERR_FRAC_BITS);
    t_b     = TW'(prod_b5 >>> ERR_FRAC_BITS);
    t_br    = TW'(prod_br >>> ERR_FRAC_BITS);
  end

  // next-row window: this column finishes, the two ahead accumulate
  always_comb begin
    wr_value    = sat_add(part_a, t_bl);
    part_a_next = sat_add(part_b, t_b);
    part_b_next = sat_add(EB'(0), t_br);
    carry_next  = t_r;
  end

endmodule

>>> hdl/error_diffusion_binarizer.sv
// Pipeline: a pixel passes the stage register, then the result register. One
// pixel per clock while the result side keeps up, held by the one read and
// one write port of each line store and the registered right-neighbour carry.
// Reset: synchronous, active high; registers return to defaults and both error
// rows read as zero at once through per-row fill counts, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module error_diffusion_binarizer #(
  parameter int MAX_WIDTH  = 2048,
  parameter int ERROR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  edb_pix_if.sink    pixel,
  edb_res_if.source  result,
  edb_cfg_if.sink    cfg
);
  import edb_pkg::*;

  localparam int EB = ERROR_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int XW = $clog2(MAX_WIDTH + 2);
  localparam int CW = (XW > LINE_WIDTH_BITS) ? XW : LINE_WIDTH_BITS;

  cfg_t regs;

  edb_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // position counters and row roles
  logic [COL_BITS-1:0] col_count;
  logic [ROW_BITS-1:0] row_count;
  logic                cur_bank;

  // stage register
  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_grey;
  logic [AW-1:0]         s1_x;
  logic                  s1_eol;
  logic                  s1_eof;
  logic                  s1_bank;

  // per-row fill counts and the two words past the fill
  logic [XW-1:0]        fill   [2];
  logic signed [EB-1:0] tail_a [2];
  logic signed [EB-1:0] tail_b [2];

  // running error window
  logic signed [EB:0]   carry;
  logic signed [EB-1:0] part_a;
  logic signed [EB-1:0] part_b;

  // result register
  logic                  o_valid;
  logic [PIXEL_BITS-1:0] o_bin;
  logic                  o_eol;
  logic                  o_eof;

  logic                  accept;
  logic                  s1_go;
  logic [CW-1:0]         line_w, width_eff, col_plus;
  logic [ROW_BITS-1:0]   height_eff;
  logic [ROW_BITS:0]     row_plus;
  logic                  in_eol, in_eof;
  logic [AW-1:0]         in_x, rd_addr;
  logic [XW-1:0]         s1_raddr, fill_cur;
  logic [EB-1:0]         rdata0, rdata1;
  logic signed [EB-1:0]  stored;
  logic [PIXEL_BITS-1:0] level;
  logic signed [EB-1:0]  wr_value, part_a_next, part_b_next;
  logic signed [EB:0]    carry_next;

  // handshakes
  assign s1_go        = s1_valid && (!o_valid || result.ready);
  assign pixel.ready  = !s1_valid || s1_go;
  assign accept       = pixel.valid && pixel.ready;

  // frame geometry of the incoming pixel
  always_comb begin
    line_w = CW'(regs.line_width);
    if (line_w == '0) begin
      width_eff = CW'(1);
    end else if (line_w > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = line_w;
    end
    height_eff = (regs.frame_height == '0) ? ROW_BITS'(1) : regs.frame_height;
    col_plus   = CW'(col_count) + CW'(1);
    row_plus   = (ROW_BITS + 1)'(row_count) + (ROW_BITS + 1)'(1);
    in_eol     = (col_plus >= width_eff);
    in_eof     = in_eol && (row_plus >= (ROW_BITS + 1)'(height_eff));
    in_x       = (CW'(col_count) >= CW'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1)
                                                    : AW'(col_count);
    rd_addr    = in_x + AW'(1);
  end

  // line stores: current row read ahead, next row written behind
  edb_line_store #(.AW(AW), .DW(EB)) u_row0 (
    .clk   (clk),
    .we    (s1_go && s1_bank),
    .waddr (s1_x),
    .wdata (wr_value),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  edb_line_store #(.AW(AW), .DW(EB)) u_row1 (
    .clk   (clk),
    .we    (s1_go && !s1_bank),
    .waddr (s1_x),
    .wdata (wr_value),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  // stored error for this column: memory below the fill, tail words, else zero
  always_comb begin
    s1_raddr = XW'(s1_x) + XW'(1);
    fill_cur = fill[s1_bank];
    if (s1_raddr < fill_cur) begin
      stored = s1_bank ? $signed(rdata1) : $signed(rdata0);
    end else if (s1_raddr == fill_cur) begin
      stored = tail_a[s1_bank];
    end else if (s1_raddr == fill_cur + XW'(1)) begin
      stored = tail_b[s1_bank];
    end else begin
      stored = '0;
    end
  end

  edb_error_path #(.EB(EB)) u_path (
    .grey        (s1_grey),
    .stored      (stored),
    .carry       (carry),
    .part_a      (part_a),
    .part_b      (part_b),
    .threshold   (regs.threshold),
    .level_low   (regs.level_low),
    .level_high  (regs.level_high),
    .level       (level),
    .wr_value    (wr_value),
    .part_a_next (part_a_next),
    .part_b_next (part_b_next),
    .carry_next  (carry_next)
  );

  // counters, stage and result valids
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      cur_bank  <= 1'b0;
      s1_valid  <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (accept) begin
        cur_bank <= cur_bank ^ in_eol;
        if (in_eof) begin
          col_count <= '0;
          row_count <= '0;
        end else if (in_eol) begin
          col_count <= '0;
          row_count <= row_count + ROW_BITS'(1);
        end else begin
          col_count <= col_count + COL_BITS'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // error rows: rotation at line end, clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '{default: '0};
      tail_a <= '{default: '0};
      tail_b <= '{default: '0};
      carry  <= '0;
      part_a <= '0;
      part_b <= '0;
    end else if (s1_go) begin
      if (s1_eof) begin
        fill   <= '{default: '0};
        tail_a <= '{default: '0};
        tail_b <= '{default: '0};
        carry  <= '0;
        part_a <= '0;
        part_b <= '0;
      end else if (s1_eol) begin
        fill[!s1_bank]   <= XW'(s1_x) + XW'(1);
        tail_a[!s1_bank] <= part_a_next;
        tail_b[!s1_bank] <= part_b_next;
        fill[s1_bank]    <= '0;
        tail_a[s1_bank]  <= '0;
        tail_b[s1_bank]  <= '0;
        carry  <= '0;
        part_a <= '0;
        part_b <= '0;
      end else begin
        carry  <= carry_next;
        part_a <= part_a_next;
        part_b <= part_b_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_grey <= pixel.grey_pixel;
      s1_x    <= in_x;
      s1_eol  <= in_eol;
      s1_eof  <= in_eof;
      s1_bank <= cur_bank;
    end
    if (s1_go) begin
      o_bin <= level;
      o_eol <= s1_eol;
      o_eof <= s1_eof;
    end
  end

  assign result.valid        = o_valid;
  assign result.bin_pixel    = o_bin;
  assign result.end_of_line  = o_eol;
  assign result.end_of_frame = o_eof;

  // checks
  `EDB_ASSERT_IMP(a_eof_has_eol, clk, rst, o_valid && o_eof, o_eol, "frame end without line end")
  `EDB_ASSERT_IMP(a_level_pick, clk, rst, o_valid, (o_bin == regs.level_low) || (o_bin == regs.level_high), "output is neither level")
  `EDB_ASSERT_NXT(a_next_row_clear, clk, rst, s1_go && s1_eol, (fill[0] == '0) || (fill[1] == '0), "next row not cleared at line end")
  `EDB_ASSERT_NXT(a_frame_clear, clk, rst, s1_go && s1_eof, (fill[0] == '0) && (fill[1] == '0) && (carry == '0), "error state left at frame end")

endmodule

>>> tb/error_diffusion_binarizer_tb.sv
// self-checking testbench of the error diffusion binarizer: pixel, result and register channels
// depends on edb_pkg, the edb interfaces and the error_diffusion_binarizer rtl
`timescale 1ns / 1ps

module error_diffusion_binarizer_tb;
  import edb_pkg::*;

  localparam int MAX_WIDTH       = 2048;
  localparam int ERROR_BITS      = 16;
  localparam int STORE_DEPTH     = MAX_WIDTH + 2;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_ITEMS    = 200;
  localparam int LONG_LINE_ITEMS = 48;
  localparam int REPORT_LIMIT    = 10;
  localparam int INDEX_COUNT     = 1 << CFG_INDEX_BITS;

  // one expected or received result word
  typedef struct packed {
    logic [PIXEL_BITS-1:0] bin_pixel;
    logic                  end_of_line;
    logic                  end_of_frame;
  } halftone_word_t;

  logic clk;
  logic rst;

  edb_pix_if pix_ch ();
  edb_res_if res_ch ();
  edb_cfg_if cfg_ch ();

  error_diffusion_binarizer #(
    .MAX_WIDTH  (MAX_WIDTH),
    .ERROR_BITS (ERROR_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_ch.sink),
    .result (res_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // predictor state: registers, both error rows and raster position
  cfg_t                         model_cfg;
  logic signed [ERROR_BITS-1:0] err_row_now   [STORE_DEPTH];
  logic signed [ERROR_BITS-1:0] err_row_below [STORE_DEPTH];
  logic [COL_BITS-1:0]          col_pos;
  logic [ROW_BITS-1:0]          row_pos;
  halftone_word_t               pending_words [$];

  bit idle_on = 1'b1;
  int fail_count  = 0;
  int words_seen  = 0;
  int pixels_in   = 0;
  int frames_out  = 0;
  int reg_writes  = 0;
  int cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still awaited", cycle_count,
             pending_words.size());
    $display("CHECK FAILED");
    $finish;
  end

  // saturate to the signed error range
  function automatic logic signed [ERROR_BITS-1:0] clamp_err(int v);
    int top;
    int bottom;
    top    = (1 << (ERROR_BITS - 1)) - 1;
    bottom = -top - 1;
    if (v > top) return ERROR_BITS'(top);
    if (v < bottom) return ERROR_BITS'(bottom);
    return ERROR_BITS'(v);
  endfunction

  function automatic void clear_err_rows();
    foreach (err_row_now[i]) begin
      err_row_now[i]   = '0;
      err_row_below[i] = '0;
    end
  endfunction

  // binarise one pixel, spread its error and step the raster position
  function automatic halftone_word_t diffuse_pixel(logic [PIXEL_BITS-1:0] grey);
    int width;
    int height;
    int x;
    int sum;
    int err;
    int level;
    halftone_word_t word;
    width = model_cfg.line_width;
    if (width == 0) width = 1;
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    height = model_cfg.frame_height;
    if (height == 0) height = 1;
    x = col_pos;
    if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;

    sum   = (int'(grey) << ERR_FRAC_BITS) + int'(err_row_now[x + 1]);
    level = (sum > (int'(model_cfg.threshold) << ERR_FRAC_BITS)) ? model_cfg.level_high
                                                                   : model_cfg.level_low;
    err   = sum - (level << ERR_FRAC_BITS);

    // weights in sixteenths, each term floored
    err_row_now[x + 2]   = clamp_err(int'(err_row_now[x + 2]) +
                                     ((err * W_RIGHT) >>> ERR_FRAC_BITS));
    err_row_below[x]     = clamp_err(int'(err_row_below[x]) +
                                     ((err * W_BELOW_LEFT) >>> ERR_FRAC_BITS));
    err_row_below[x + 1] = clamp_err(int'(err_row_below[x + 1]) +
                                     ((err * W_BELOW) >>> ERR_FRAC_BITS));
    err_row_below[x + 2] = clamp_err(int'(err_row_below[x + 2]) +
                                     ((err * W_BELOW_RIGHT) >>> ERR_FRAC_BITS));

    word.bin_pixel    = PIXEL_BITS'(level);
    word.end_of_line  = (int'(col_pos) + 1 >= width);
    word.end_of_frame = word.end_of_line && (int'(row_pos) + 1 >= height);

    if (word.end_of_frame) begin
      clear_err_rows();
      col_pos = '0;
      row_pos = '0;
    end else if (word.end_of_line) begin
      err_row_now = err_row_below;
      foreach (err_row_below[i]) err_row_below[i] = '0;
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return word;
  endfunction

  // check each result word, then follow register writes and accepted pixels
  always @(posedge clk) begin : predict_and_check
    halftone_word_t got;
    halftone_word_t want;
    if (rst) begin
      model_cfg = '{threshold: THRESHOLD_RST, level_low: LEVEL_LOW_RST,
                    level_high: LEVEL_HIGH_RST, line_width: LINE_WIDTH_RST,
                    frame_height: FRAME_HEIGHT_RST};
      clear_err_rows();
      col_pos = '0;
      row_pos = '0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{bin_pixel: res_ch.bin_pixel, end_of_line: res_ch.end_of_line,
                end_of_frame: res_ch.end_of_frame};
        words_seen++;
        if (got.end_of_frame) frames_out++;
        if (pending_words.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("word %0d arrived with nothing awaited: bin %0d eol %0b eof %0b",
                     words_seen, got.bin_pixel, got.end_of_line, got.end_of_frame);
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("word %0d: expected bin %0d eol %0b eof %0b, got bin %0d eol %0b eof %0b",
                       words_seen, want.bin_pixel, want.end_of_line, want.end_of_frame,
                       got.bin_pixel, got.end_of_line, got.end_of_frame);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          REG_THRESHOLD:    model_cfg.threshold    = cfg_ch.data[PIXEL_BITS-1:0];
          REG_LEVEL_LOW:    model_cfg.level_low    = cfg_ch.data[PIXEL_BITS-1:0];
          REG_LEVEL_HIGH:   model_cfg.level_high   = cfg_ch.data[PIXEL_BITS-1:0];
          REG_LINE_WIDTH:   model_cfg.line_width   = cfg_ch.data[LINE_WIDTH_BITS-1:0];
          REG_FRAME_HEIGHT: model_cfg.frame_height = cfg_ch.data[ROW_BITS-1:0];
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) begin
        pixels_in++;
        pending_words.push_back(diffuse_pixel(pix_ch.grey_pixel));
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // offer one pixel word, with an occasional gap ahead of it
  task automatic send_pixel(logic [PIXEL_BITS-1:0] grey);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.grey_pixel <= grey;
    do begin
      @(posedge clk);
    end while (!pix_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits carry noise
  task automatic set_frame(int width, int height);
    write_reg(REG_LINE_WIDTH, {(CFG_DATA_BITS-LINE_WIDTH_BITS)'($urandom),
                               LINE_WIDTH_BITS'(width)});
    write_reg(REG_FRAME_HEIGHT, ROW_BITS'(height));
  endtask

  task automatic set_levels(int thr, int lo, int hi);
    write_reg(REG_THRESHOLD,  {(CFG_DATA_BITS-PIXEL_BITS)'($urandom), PIXEL_BITS'(thr)});
    write_reg(REG_LEVEL_LOW,  {(CFG_DATA_BITS-PIXEL_BITS)'($urandom), PIXEL_BITS'(lo)});
    write_reg(REG_LEVEL_HIGH, {(CFG_DATA_BITS-PIXEL_BITS)'($urandom), PIXEL_BITS'(hi)});
  endtask

  // stop offering and wait until every awaited word is back
  task automatic drain();
    pix_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIXEL_BITS-1:0] pick_grey();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // register defaults straight out of reset, threshold edge included
  task automatic test_reset_defaults();
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    send_pixel(8'd129);
    send_pixel(8'd127);
    drain();
  endtask

  // inverted levels and both threshold extremes
  task automatic test_level_extremes();
    set_frame(3, 2);
    set_levels(0, 255, 0);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    drain();
    write_reg(REG_THRESHOLD, 16'hFF);
    send_pixel(8'd255);
    send_pixel(8'd255);
    drain();
  endtask

  // zero width and height act as one
  task automatic test_degenerate_sizes();
    set_levels(128, 0, 255);
    set_frame(0, 0);
    repeat (3) send_pixel(pick_grey());
    drain();
    set_frame(1, 3);
    repeat (3) send_pixel(pick_grey());
    drain();
  endtask

  // shrink width and height while part way through a line
  task automatic test_resize_mid_line();
    set_frame(8, 4);
    repeat (3) send_pixel(pick_grey());
    drain();
    write_reg(REG_LINE_WIDTH, 16'd2);
    repeat (2) send_pixel(pick_grey());
    drain();
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    send_pixel(pick_grey());
    drain();
  endtask

  // writes to indexes past the last register leave everything alone
  task automatic test_unknown_index();
    for (int i = int'(REG_FRAME_HEIGHT) + 1; i < INDEX_COUNT; i++)
      write_reg(CFG_INDEX_BITS'(i), CFG_DATA_BITS'($urandom));
    repeat (2) send_pixel(pick_grey());
    drain();
  endtask

  // drive stored errors into both saturation rails, then make them visible
  task automatic test_error_saturation();
    set_frame(3, 255);
    set_levels(255, 0, 0);
    repeat (60) send_pixel(8'd255);
    drain();
    set_levels(128, 0, 255);
    repeat (12) send_pixel(pick_grey());
    drain();
    set_levels(0, 255, 255);
    repeat (60) send_pixel(8'd0);
    drain();
    set_levels(128, 0, 255);
    repeat (12) send_pixel(pick_grey());
    drain();
  endtask

  // widest line setting, then a width above the store, both cut short
  task automatic test_full_width_lines();
    set_levels($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    set_frame(MAX_WIDTH, 2);
    repeat (LONG_LINE_ITEMS) send_pixel(pick_grey());
    drain();
    write_reg(REG_LINE_WIDTH, 16'hFFFF);
    repeat (LONG_LINE_ITEMS) send_pixel(pick_grey());
    drain();
  endtask

  // random settings, mostly small frames, some cut short
  task automatic test_random_settings();
    int sent;
    int w;
    int h;
    int thr;
    int eff_w;
    int eff_h;
    int n;
    int cap;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 4095);
        1, 2:    w = $urandom_range(17, 64);
        default: w = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = 65535;
        2:       h = $urandom_range(0, 65535);
        default: h = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 3))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      set_levels(thr, $urandom_range(0, 255), $urandom_range(0, 255));
      set_frame(w, h);
      eff_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      eff_h = (h == 0) ? 1 : h;
      cap   = (eff_w * 2 > 120) ? 120 : eff_w * 2;
      if ($urandom_range(0, 3) == 0 || eff_w * eff_h > 120) n = $urandom_range(1, cap);
      else n = eff_w * eff_h;
      repeat (n) send_pixel(pick_grey());
      drain();
      sent += n;
    end
  endtask

  // closing stretch with both sides always willing
  task automatic test_back_to_back();
    idle_on = 1'b0;
    // let any stall burst still running die out
    repeat (20) @(posedge clk);
    set_levels($urandom_range(0, 255), 0, 255);
    set_frame(7, 65535);
    repeat (150) send_pixel(pick_grey());
    drain();
    set_frame(5, 3);
    repeat (60) send_pixel(pick_grey());
    drain();
  endtask

  // reset, tests in turn, final verdict
  initial begin
    rst               <= 1'b1;
    pix_ch.valid      <= 1'b0;
    pix_ch.grey_pixel <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_level_extremes();
    test_degenerate_sizes();
    test_resize_mid_line();
    test_unknown_index();
    test_error_saturation();
    test_full_width_lines();
    idle_on = 1'b1;
    test_random_settings();
    test_back_to_back();

    $display("%0d pixels in, %0d words out, %0d frames closed, %0d register writes",
             pixels_in, words_seen, frames_out, reg_writes);
    $display("covered degenerate and long lines, error saturation and %0d failures",
             fail_count);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/edb_pkg.sv
hdl/edb_if.sv
hdl/edb_cfg_regs.sv
hdl/edb_line_store.sv
hdl/edb_error_path.sv
hdl/error_diffusion_binarizer.sv
tb/error_diffusion_binarizer_tb.sv
